@@ hdl/swm_pkg.sv @@
package swm_pkg;

	localparam int DATA_W         = 32;
	localparam int LEN_W          = 7;
	localparam int WINDOW_MAX_DEF = 64;
	localparam logic [LEN_W-1:0] LEN_RST = 7'd3;

	// Broadcast to every cell: what the row does in this cycle.
	typedef struct packed {
		logic step;   // a sample enters, the oldest one may leave
		logic purge;  // compaction only: the oldest entry leaves
	} ctrl_t;

	// What a cell shows its left neighbour about itself.
	typedef struct packed {
		logic gt;     // holds a valid entry greater than the incoming sample
		logic valid;  // holds a valid entry
	} nb_flags_t;

endpackage

@@ hdl/sliding_window_median_top.sv @@
// Running median filter over the most recent window_length signed samples.
//
// Input stream: s_axis_tdata carries the 32-bit sample, s_axis_tuser the
// start-of-sequence flag, which empties the window before that sample enters.
// Output stream: m_axis_tdata carries the lower median of the full window.
// A word yields a median only once the window holds window_length samples.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the
// window length; it is always ready and should be used only while idle.
// A length of 0 acts as 1, any length above WINDOW_MAX acts as WINDOW_MAX.
//
// The window lives in a row of WINDOW_MAX cells kept in ascending order. Each
// cell drops the oldest entry and makes room for the new one, looking at its
// two neighbours and at the seen chain from its left, so one word is taken
// every clock unless compaction or a held median stalls the input. A due
// median is flagged in pend_s1, then moved to the output register for m_axis.
// After a length reduction, each surplus sample is compacted out first.
// Reset empties the window and sets the length to 3. When the receiver stalls,
// one median waits in the output register and one more may wait behind it;
// input then stops until the output is taken.
module sliding_window_median_top #(
	parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] sample
	input  logic        s_axis_tuser,  // [0] start_of_sequence
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] median
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data       // window_length
);

	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int DW = swm_pkg::DATA_W;

	logic [swm_pkg::LEN_W-1:0] len_q;
	logic [CW-1:0]             fill_q;
	logic                      pend_s1;
	logic                      out_valid_q;
	logic [DW-1:0]             out_data_q;

	logic [31:0]               wl32;
	logic [CW-1:0]             len_eff;
	logic [CW-1:0]             fill_eff;
	logic [CW-1:0]             kept;
	logic [CW-1:0]             new_fill;
	logic [AW-1:0]             thr;
	logic [AW-1:0]             mid;
	logic                      purge_need;
	logic                      move_ok;
	logic                      step;
	logic                      purge_en;
	logic                      pend_move;
	swm_pkg::ctrl_t            ctrl;
	logic signed [DW-1:0]      sample;

	logic signed [DW-1:0]      cell_val   [WINDOW_MAX];
	logic [AW-1:0]             cell_age   [WINDOW_MAX];
	swm_pkg::nb_flags_t        cell_flags [WINDOW_MAX];
	logic [WINDOW_MAX:0]       seen_chain;
	logic [WINDOW_MAX:0]       gtc_chain;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= swm_pkg::LEN_RST;
		end else if (cfg_valid) begin
			len_q <= cfg_data;
		end
	end

	// Effective window length, clamped to the range the row can hold.
	always_comb begin
		wl32 = 32'(len_q);
		if (wl32 == 32'd0) begin
			len_eff = CW'(1);
		end else if (wl32 > 32'(WINDOW_MAX)) begin
			len_eff = CW'(WINDOW_MAX);
		end else begin
			len_eff = wl32[CW-1:0];
		end
	end

	assign mid = AW'((len_eff - 1'b1) >> 1);

	// A held median must leave before the row changes underneath it.
	assign move_ok    = !pend_s1 || !out_valid_q || m_axis_tready;
	assign purge_need = fill_q > len_eff;
	assign purge_en   = purge_need && move_ok;
	assign s_axis_tready = !purge_need && move_ok;
	assign step       = s_axis_tvalid && s_axis_tready;
	assign pend_move  = pend_s1 && (!out_valid_q || m_axis_tready);

	assign ctrl.step  = step;
	assign ctrl.purge = purge_en;
	assign sample     = $signed(s_axis_tdata);
	assign fill_eff   = (s_axis_tuser && !purge_en) ? '0 : fill_q;

	// While compacting the oldest entry has age fill-1, otherwise len-1.
	assign thr = purge_en ? AW'(fill_q - 1'b1) : AW'(len_eff - 1'b1);

	assign seen_chain[0] = 1'b0;
	assign gtc_chain[0]  = 1'b0;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic signed [DW-1:0] p_val;
		logic [AW-1:0]        p_age;
		logic signed [DW-1:0] n_val;
		logic [AW-1:0]        n_age;
		swm_pkg::nb_flags_t   n_flags;

		if (i == 0) begin : g_first
			assign p_val = '0;
			assign p_age = '0;
		end else begin : g_mid
			assign p_val = cell_val[i-1];
			assign p_age = cell_age[i-1];
		end

		if (i == WINDOW_MAX - 1) begin : g_last
			assign n_val   = '0;
			assign n_age   = '0;
			assign n_flags = '0;
		end else begin : g_inner
			assign n_val   = cell_val[i+1];
			assign n_age   = cell_age[i+1];
			assign n_flags = cell_flags[i+1];
		end

		swm_cell #(
			.IDX (i),
			.AW  (AW),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.sample     (sample),
			.fill_eff   (fill_eff),
			.thr        (thr),
			.prev_val   (p_val),
			.prev_age   (p_age),
			.seen_in    (seen_chain[i]),
			.gtc_in     (gtc_chain[i]),
			.next_val   (n_val),
			.next_age   (n_age),
			.next_flags (n_flags),
			.val_q      (cell_val[i]),
			.age_q      (cell_age[i]),
			.flags      (cell_flags[i]),
			.seen_out   (seen_chain[i+1]),
			.gtc_out    (gtc_chain[i+1])
		);
	end

	// Entries left after the oldest one has gone, then the new sample joins.
	assign kept     = fill_eff - CW'(seen_chain[WINDOW_MAX]);
	assign new_fill = kept + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (purge_en) begin
			fill_q <= fill_q - 1'b1;
		end else if (step) begin
			fill_q <= new_fill;
		end
	end

	// pend_s1 marks that the row now holds a full window whose median is due.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				pend_s1 <= new_fill >= len_eff;
			end else if (pend_move) begin
				pend_s1 <= 1'b0;
			end
			if (pend_move) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_move) begin
			out_data_q <= cell_val[mid];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_no_step_in_purge: assert property (@(posedge clk) disable iff (!arst_n)
		purge_en |-> !step)
		else $error("word accepted during compaction");

	a_purge_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		purge_en |=> fill_q == $past(fill_q) - 1'b1)
		else $error("compaction did not remove exactly one entry");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(WINDOW_MAX))
		else $error("fill count beyond the row length");

	a_step_fills: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> fill_q != '0)
		else $error("window empty after a word entered");

endmodule

@@ hdl/swm_cell.sv @@
module swm_cell #(
	parameter int IDX = 0,
	parameter int AW  = 6,
	parameter int CW  = 7
) (
	input  logic                              clk,
	input  swm_pkg::ctrl_t                    ctrl,
	input  logic signed [swm_pkg::DATA_W-1:0] sample,
	input  logic [CW-1:0]                     fill_eff,
	input  logic [AW-1:0]                     thr,
	input  logic signed [swm_pkg::DATA_W-1:0] prev_val,
	input  logic [AW-1:0]                     prev_age,
	input  logic                              seen_in,
	input  logic                              gtc_in,
	input  logic signed [swm_pkg::DATA_W-1:0] next_val,
	input  logic [AW-1:0]                     next_age,
	input  swm_pkg::nb_flags_t                next_flags,
	output logic signed [swm_pkg::DATA_W-1:0] val_q,
	output logic [AW-1:0]                     age_q,
	output swm_pkg::nb_flags_t                flags,
	output logic                              seen_out,
	output logic                              gtc_out
);

	logic                              valid;
	logic                              drop;
	logic                              seen;
	logic                              cvalid;
	logic                              taken;
	logic signed [swm_pkg::DATA_W-1:0] c_val;
	logic [AW-1:0]                     c_age;
	logic signed [swm_pkg::DATA_W-1:0] l_val;
	logic [AW-1:0]                     l_age;
	logic signed [swm_pkg::DATA_W-1:0] val_d;
	logic [AW-1:0]                     age_d;

	assign valid       = fill_eff > CW'(IDX);
	assign flags.valid = valid;
	assign flags.gt    = valid && (val_q > sample);

	// The leaving entry is the oldest one; every cell from it rightwards sees it.
	assign drop     = valid && (age_q >= thr);
	assign seen     = seen_in | drop;
	assign seen_out = seen;

	// Contents of this place once the leaving entry has been squeezed out.
	assign c_val   = seen ? next_val : val_q;
	assign c_age   = seen ? next_age : age_q;
	assign cvalid  = seen ? next_flags.valid : valid;
	assign gtc_out = seen ? next_flags.gt : flags.gt;

	// Contents of the place to the left after the squeeze.
	assign l_val = seen_in ? val_q : prev_val;
	assign l_age = seen_in ? age_q : prev_age;

	assign taken = !gtc_out && cvalid;

	always_comb begin
		val_d = val_q;
		age_d = age_q;
		if (ctrl.purge) begin
			val_d = c_val;
			age_d = c_age;
		end else if (ctrl.step) begin
			if (taken) begin
				val_d = c_val;
				age_d = AW'(c_age + 1'b1);
			end else if (gtc_in) begin
				val_d = l_val;
				age_d = AW'(l_age + 1'b1);
			end else begin
				val_d = sample;
				age_d = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
		age_q <= age_d;
	end

endmodule
